@@ src/tvdi_pkg.sv @@
// Package: shared types and constants for the vertex dedup indexer.
`timescale 1ns / 1ps
package tvdi_pkg;

    localparam int COORD_W   = 32;
    localparam int IDX_OUT_W = 12;
    localparam int UV_W      = 13;
    localparam int CNT_W     = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_ACCEPTED   = 2'd0,
        ST_DEGENERATE = 2'd1,
        ST_DUPLICATE  = 2'd2,
        ST_FULL       = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic v_rd;
        logic v_inc;
        logic v_hit;
        logic v_append;
        logic t_rd;
        logic t_inc;
        logic fin_full;
        logic fin_degen;
        logic fin_dup;
        logic fin_accept;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic v_scan_end;
        logic v_table_full;
        logic v_match;
        logic corner_last;
        logic degenerate;
        logic t_scan_end;
        logic t_table_full;
        logic t_match;
        logic out_free;
    } sts_t;

endpackage

@@ src/tvdi_ram.sv @@
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module tvdi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/tvdi_ctrl.sv @@
// Controller state machine: sequences corner scans, triangle scan and result hand-off.
`timescale 1ns / 1ps
module tvdi_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  tvdi_pkg::sts_t sts,
    output tvdi_pkg::cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_V_CHK = 7'b0000010,
        S_V_CMP = 7'b0000100,
        S_DEGEN = 7'b0001000,
        S_T_CHK = 7'b0010000,
        S_T_CMP = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_V_CHK;
                end
            end
            S_V_CHK:
            begin
                if (sts.v_scan_end)
                begin
                    if (sts.v_table_full)
                    begin
                        cmd.fin_full = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.v_append = 1'b1;
                        state_next   = sts.corner_last ? S_DEGEN : S_V_CHK;
                    end
                end
                else
                begin
                    cmd.v_rd   = 1'b1;
                    state_next = S_V_CMP;
                end
            end
            S_V_CMP:
            begin
                if (sts.v_match)
                begin
                    cmd.v_hit  = 1'b1;
                    state_next = sts.corner_last ? S_DEGEN : S_V_CHK;
                end
                else
                begin
                    cmd.v_inc  = 1'b1;
                    state_next = S_V_CHK;
                end
            end
            S_DEGEN:
            begin
                if (sts.degenerate)
                begin
                    cmd.fin_degen = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_T_CHK;
                end
            end
            S_T_CHK:
            begin
                if (sts.t_scan_end)
                begin
                    cmd.fin_full   = sts.t_table_full;
                    cmd.fin_accept = !sts.t_table_full;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.t_rd   = 1'b1;
                    state_next = S_T_CMP;
                end
            end
            S_T_CMP:
            begin
                if (sts.t_match)
                begin
                    cmd.fin_dup = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.t_inc  = 1'b1;
                    state_next = S_T_CHK;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/tvdi_dp.sv @@
// Datapath: input latch, vertex and triangle tables, scan counter, counters, output register.
`timescale 1ns / 1ps
module tvdi_dp #(
    parameter int MAX_VERTICES  = 4096,
    parameter int MAX_TRIANGLES = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tvdi_pkg::cmd_t cmd,
    output tvdi_pkg::sts_t sts,
    input  logic [383:0]   s_tdata,
    input  logic           normals_enabled,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [183:0]   m_tdata
);

    localparam int VIW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int VFW = $clog2(MAX_VERTICES + 1);
    localparam int TIW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int TFW = $clog2(MAX_TRIANGLES + 1);
    localparam int SW  = (VFW > TFW) ? VFW : TFW;
    localparam int VW  = 3 * tvdi_pkg::COORD_W;

    logic [VW-1:0]  corner_reg [3];
    logic [VW-1:0]  normal_reg;
    logic [1:0]     k_reg;
    logic [SW-1:0]  scan_reg;
    logic [VFW-1:0] lfill_reg;
    logic [VFW-1:0] vfill_reg;
    logic [TFW-1:0] tfill_reg;
    logic [VIW-1:0] idx_reg [3];
    logic [tvdi_pkg::CNT_W-1:0] degen_cnt_reg;
    logic [tvdi_pkg::CNT_W-1:0] dup_cnt_reg;
    tvdi_pkg::status_t res_status_reg;
    logic           out_valid_reg;
    logic [183:0]   out_data_reg;

    logic [VW-1:0]    cur_corner;
    logic [VW-1:0]    v_rdata;
    logic [3*VIW-1:0] t_rdata;
    logic [3*VIW-1:0] tri_key;
    logic             adv;

    assign cur_corner = corner_reg[k_reg];
    assign tri_key    = {idx_reg[2], idx_reg[1], idx_reg[0]};
    assign adv        = cmd.v_hit || cmd.v_append;

    tvdi_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vtx_ram (
        .clk   (clk),
        .we    (cmd.v_append),
        .waddr (lfill_reg[VIW-1:0]),
        .wdata (cur_corner),
        .re    (cmd.v_rd),
        .raddr (scan_reg[VIW-1:0]),
        .rdata (v_rdata)
    );

    tvdi_ram #(.WIDTH(3 * VIW), .DEPTH(MAX_TRIANGLES)) u_tri_ram (
        .clk   (clk),
        .we    (cmd.fin_accept),
        .waddr (tfill_reg[TIW-1:0]),
        .wdata (tri_key),
        .re    (cmd.t_rd),
        .raddr (scan_reg[TIW-1:0]),
        .rdata (t_rdata)
    );

    always_comb
    begin
        sts.v_scan_end   = (scan_reg >= SW'(lfill_reg));
        sts.v_table_full = (lfill_reg == VFW'(MAX_VERTICES));
        sts.v_match      = (v_rdata == cur_corner);
        sts.corner_last  = (k_reg == 2'd2);
        sts.degenerate   = (idx_reg[0] == idx_reg[1]) || (idx_reg[0] == idx_reg[2])
                           || (idx_reg[1] == idx_reg[2]);
        sts.t_scan_end   = (scan_reg >= SW'(tfill_reg));
        sts.t_table_full = (tfill_reg == TFW'(MAX_TRIANGLES));
        sts.t_match      = (t_rdata == tri_key);
        sts.out_free     = !out_valid_reg || m_tready;
    end

    // input latch and per-triangle working state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            corner_reg[0] <= s_tdata[VW-1:0];
            corner_reg[1] <= s_tdata[2*VW-1:VW];
            corner_reg[2] <= s_tdata[3*VW-1:2*VW];
            normal_reg    <= s_tdata[4*VW-1:3*VW];
        end
        if (adv)
        begin
            idx_reg[k_reg] <= cmd.v_hit ? scan_reg[VIW-1:0] : lfill_reg[VIW-1:0];
        end
        if (cmd.fin_full)
        begin
            res_status_reg <= tvdi_pkg::ST_FULL;
        end
        else if (cmd.fin_degen)
        begin
            res_status_reg <= tvdi_pkg::ST_DEGENERATE;
        end
        else if (cmd.fin_dup)
        begin
            res_status_reg <= tvdi_pkg::ST_DUPLICATE;
        end
        else if (cmd.fin_accept)
        begin
            res_status_reg <= tvdi_pkg::ST_ACCEPTED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            scan_reg      <= '0;
            lfill_reg     <= '0;
            vfill_reg     <= '0;
            tfill_reg     <= '0;
            degen_cnt_reg <= '0;
            dup_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                k_reg     <= '0;
                scan_reg  <= '0;
                lfill_reg <= vfill_reg;
            end
            if (cmd.v_inc || cmd.t_inc)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (adv)
            begin
                scan_reg <= '0;
                k_reg    <= k_reg + 1'b1;
            end
            if (cmd.v_append)
            begin
                lfill_reg <= lfill_reg + 1'b1;
            end
            if (cmd.fin_degen || cmd.fin_dup || cmd.fin_accept)
            begin
                vfill_reg <= lfill_reg;
            end
            if (cmd.fin_accept)
            begin
                tfill_reg <= tfill_reg + 1'b1;
            end
            if (cmd.fin_degen && (degen_cnt_reg != tvdi_pkg::CNT_MAX))
            begin
                degen_cnt_reg <= degen_cnt_reg + 1'b1;
            end
            if (cmd.fin_dup && (dup_cnt_reg != tvdi_pkg::CNT_MAX))
            begin
                dup_cnt_reg <= dup_cnt_reg + 1'b1;
            end
        end
    end

    // output register
    logic [183:0] out_data_next;
    logic         is_full;
    logic         pass_normal;

    always_comb
    begin
        is_full       = (res_status_reg == tvdi_pkg::ST_FULL);
        pass_normal   = (res_status_reg == tvdi_pkg::ST_ACCEPTED) && normals_enabled;
        out_data_next = '0;
        out_data_next[1:0]     = res_status_reg;
        out_data_next[13:2]    = is_full ? '0 : tvdi_pkg::IDX_OUT_W'(idx_reg[0]);
        out_data_next[25:14]   = is_full ? '0 : tvdi_pkg::IDX_OUT_W'(idx_reg[1]);
        out_data_next[37:26]   = is_full ? '0 : tvdi_pkg::IDX_OUT_W'(idx_reg[2]);
        out_data_next[133:38]  = pass_normal ? normal_reg : '0;
        out_data_next[146:134] = tvdi_pkg::UV_W'(vfill_reg);
        out_data_next[162:147] = degen_cnt_reg;
        out_data_next[178:163] = dup_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ src/triangle_vertex_dedup_indexer_unit.sv @@
// Top level: configuration register, controller and datapath of the vertex dedup indexer.
`timescale 1ns / 1ps
// Takes one triangle per input transfer and returns one result transfer. Each corner is
// found by a linear scan of the vertex table through the registered RAM read and is
// appended as a new vertex if no match is found; the index triple is then scanned
// against the triangle table unless two indices are equal. The result waits in an
// output register, so the next triangle can start while it is held. No clearing pass
// follows reset: both tables are tracked by fill counts.
module triangle_vertex_dedup_indexer_unit #(
    parameter int MAX_VERTICES  = 4096,
    parameter int MAX_TRIANGLES = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // corner_a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, facet_normal_x, _y, _z
    input  logic [383:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, index_a, index_b, index_c, normal_out_x, _y, _z, unique_vertices,
    // degenerate_total, duplicate_total, zero pad
    output logic [183:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [0:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    tvdi_pkg::cmd_t cmd;
    tvdi_pkg::sts_t sts;
    logic           normals_enabled_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normals_enabled_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && (paddr == 1'b0))
        begin
            normals_enabled_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr == 1'b0) ? {31'd0, normals_enabled_reg} : 32'd0;

    tvdi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tvdi_dp #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .s_tdata         (s_tdata),
        .normals_enabled (normals_enabled_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

endmodule

@@ src/tvdi_checker.sv @@
// Port-level checker for the vertex dedup indexer, bound to the top level.
`timescale 1ns / 1ps
module tvdi_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [183:0] m_tdata
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_full_zero_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == tvdi_pkg::ST_FULL) |-> (m_tdata[37:2] == '0))
        else $error("full result carries nonzero indices");

    a_normal_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != tvdi_pkg::ST_ACCEPTED) |-> (m_tdata[133:38] == '0))
        else $error("normal passed on rejected triangle");

    a_degen_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == tvdi_pkg::ST_DEGENERATE) |->
        ((m_tdata[13:2] == m_tdata[25:14]) || (m_tdata[13:2] == m_tdata[37:26])
         || (m_tdata[25:14] == m_tdata[37:26])))
        else $error("degenerate result with distinct indices");

endmodule

bind triangle_vertex_dedup_indexer_unit tvdi_checker u_tvdi_checker (.*);
